>>> sv/mciir_pkg.sv
// ----------------------------------------------------------------------------
// mciir_pkg: shared types and constants
// Sample, coefficient and payload types, CSR map and tap helpers for the
// multichannel direct form one IIR filter.
// ----------------------------------------------------------------------------
package mciir_pkg;

   localparam int Order        = 2;
   localparam int Channels     = 6;
   localparam int NumFields    = 6;
   localparam int SampleWidth  = 32;
   localparam int ProdWidth    = 2 * SampleWidth;
   localparam int SumWidth     = ProdWidth + 4;
   localparam int FracDrop     = 28;
   localparam int CsrAddrWidth = 5;
   localparam int CsrDataWidth = 32;

   typedef logic signed [SampleWidth-1:0] sample_type;
   typedef sample_type [NumFields-1:0]    sample_vec_type;

   localparam sample_type SampleMax = sample_type'(32'sh7fff_ffff);
   localparam sample_type SampleMin = sample_type'(32'sh8000_0000);
   localparam logic signed [SumWidth-1:0] HalfLsb =
      SumWidth'(64'sd1 <<< (FracDrop - 1));

   typedef struct packed {
      sample_type x_ch0;
      sample_type x_ch1;
      sample_type x_ch2;
      sample_type x_ch3;
      sample_type x_ch4;
      sample_type x_ch5;
   } req_data_type;

   typedef struct packed {
      sample_type y_ch0;
      sample_type y_ch1;
      sample_type y_ch2;
      sample_type y_ch3;
      sample_type y_ch4;
      sample_type y_ch5;
   } rsp_data_type;

   typedef struct packed {
      sample_type b0;
      sample_type b1;
      sample_type b2;
      sample_type a1;
      sample_type a2;
   } coef_type;

   // register index within the CSR map (byte address / 4)
   typedef enum logic [2:0] {
      CSR_B0 = 3'd0,
      CSR_B1 = 3'd1,
      CSR_B2 = 3'd2,
      CSR_A1 = 3'd3,
      CSR_A2 = 3'd4
   } csr_reg_type;

   // feedforward weight of tap k; taps past second order weigh zero
   function automatic sample_type coef_b_at(coef_type coef, int k);
      sample_type w;
      w = '0;
      if (k == 0) w = coef.b0;
      else if (k == 1) w = coef.b1;
      else if (k == 2) w = coef.b2;
      return w;
   endfunction

   // feedback weight of tap k; the leading coefficient is implied
   function automatic sample_type coef_a_at(coef_type coef, int k);
      sample_type w;
      w = '0;
      if (k == 1) w = coef.a1;
      else if (k == 2) w = coef.a2;
      return w;
   endfunction

   function automatic sample_vec_type unpack_req(req_data_type d);
      sample_vec_type v;
      v[0] = d.x_ch0;
      v[1] = d.x_ch1;
      v[2] = d.x_ch2;
      v[3] = d.x_ch3;
      v[4] = d.x_ch4;
      v[5] = d.x_ch5;
      return v;
   endfunction

   function automatic rsp_data_type pack_rsp(sample_vec_type v);
      rsp_data_type d;
      d.y_ch0 = v[0];
      d.y_ch1 = v[1];
      d.y_ch2 = v[2];
      d.y_ch3 = v[3];
      d.y_ch4 = v[4];
      d.y_ch5 = v[5];
      return d;
   endfunction

endpackage

>>> sv/multichannel_iir_direct_form_one.sv
// ----------------------------------------------------------------------------
// multichannel_iir_direct_form_one: six-channel second-order IIR filter
// Direct form one, Q16.16 samples, Q4.28 coefficients, rounded and
// saturated outputs, coefficients written over an APB-style port.
// ----------------------------------------------------------------------------
// Path: a result is offered once its vector has passed the input register
//   and then the result register; a full, untaken result register stalls it.
// Throughput: one vector per cycle while rsp_ready is high; the recursion
//   closes through the combinational per-channel multiply, sum, saturate logic.
// Reset: clears coefficients, all channel histories and both valid flags.
// ----------------------------------------------------------------------------
module multichannel_iir_direct_form_one #(
   parameter int ORDER    = mciir_pkg::Order,
   parameter int CHANNELS = mciir_pkg::Channels
) (
   input  logic                               clock,
   input  logic                               reset,
   // input channel
   input  logic                               req_valid,
   output logic                               req_ready,
   input  mciir_pkg::req_data_type            req_data,
   // result channel
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output mciir_pkg::rsp_data_type            rsp_data,
   // configuration port
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [mciir_pkg::CsrAddrWidth-1:0] paddr,
   input  logic [mciir_pkg::CsrDataWidth-1:0] pwdata,
   output logic [mciir_pkg::CsrDataWidth-1:0] prdata,
   output logic                               pready
);

   mciir_pkg::coef_type       coef;

   // input register: holds the accepted vector while it is being filtered
   logic                      in_valid_ff;
   logic                      in_valid_in;
   mciir_pkg::req_data_type   in_data_ff;
   mciir_pkg::req_data_type   in_data_in;

   // result register
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   mciir_pkg::rsp_data_type   rsp_data_ff;
   mciir_pkg::rsp_data_type   rsp_data_in;

   logic                      fire;
   logic                      req_xfer;
   mciir_pkg::sample_vec_type x_vec;
   mciir_pkg::sample_vec_type y_vec;
   mciir_pkg::sample_type     chan_y [CHANNELS];

   mciir_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .coef    (coef)
   );

   // Filter the held vector whenever the result register is free or is
   // being emptied in this same cycle; the channel histories advance with it.
   assign fire      = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || fire;
   assign req_xfer  = req_valid && req_ready;
   assign x_vec     = mciir_pkg::unpack_req(in_data_ff);

   for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
      mciir_chan #(
         .ORDER (ORDER)
      ) u_chan (
         .clock   (clock),
         .reset   (reset),
         .advance (fire),
         .coef    (coef),
         .x       (x_vec[c]),
         .y       (chan_y[c])
      );
   end

   // Channels that are not built report zero.
   always_comb begin
      y_vec = '0;
      for (int c = 0; c < CHANNELS; c++) begin
         y_vec[c] = chan_y[c];
      end
   end

   always_comb begin
      // input register: load on transfer, drop once filtered
      in_data_in  = in_data_ff;
      in_valid_in = in_valid_ff;
      if (req_xfer) begin
         in_data_in  = req_data;
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
      // result register: load on fire, drop when taken, else hold
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_data_in  = mciir_pkg::pack_rsp(y_vec);
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A held vector that cannot fire keeps its slot and blocks new transfers.
   a_hold_blocks_req : assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !fire |-> !req_ready)
      else $error("input transfer taken while held vector is stalled");

   // A stalled vector stays in the input register unchanged.
   a_stall_holds_input : assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !fire |=> in_valid_ff && $stable(in_data_ff))
      else $error("stalled input vector lost or changed");

   // A new result only ever comes from a fired vector.
   a_result_from_fire : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(fire))
      else $error("result appeared without a filtered vector");

endmodule

>>> sv/mciir_csr.sv
// ----------------------------------------------------------------------------
// mciir_csr: coefficient registers
// APB-style slave holding the five Q4.28 filter coefficients.
// ----------------------------------------------------------------------------
module mciir_csr (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    psel,
   input  logic                                    penable,
   input  logic                                    pwrite,
   input  logic [mciir_pkg::CsrAddrWidth-1:0]      paddr,
   input  logic [mciir_pkg::CsrDataWidth-1:0]      pwdata,
   output logic [mciir_pkg::CsrDataWidth-1:0]      prdata,
   output logic                                    pready,
   output mciir_pkg::coef_type                     coef
);

   mciir_pkg::coef_type    coef_ff;
   mciir_pkg::coef_type    coef_in;
   mciir_pkg::csr_reg_type reg_sel;
   logic                   wr_en;

   assign reg_sel = mciir_pkg::csr_reg_type'(paddr[mciir_pkg::CsrAddrWidth-1:2]);
   assign wr_en   = psel && penable && pwrite && pready;
   assign pready  = 1'b1;
   assign coef    = coef_ff;

   always_comb begin
      coef_in = coef_ff;
      if (wr_en) begin
         unique case (reg_sel)
            mciir_pkg::CSR_B0: coef_in.b0 = pwdata;
            mciir_pkg::CSR_B1: coef_in.b1 = pwdata;
            mciir_pkg::CSR_B2: coef_in.b2 = pwdata;
            mciir_pkg::CSR_A1: coef_in.a1 = pwdata;
            mciir_pkg::CSR_A2: coef_in.a2 = pwdata;
            default: coef_in = coef_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         mciir_pkg::CSR_B0: prdata = coef_ff.b0;
         mciir_pkg::CSR_B1: prdata = coef_ff.b1;
         mciir_pkg::CSR_B2: prdata = coef_ff.b2;
         mciir_pkg::CSR_A1: prdata = coef_ff.a1;
         mciir_pkg::CSR_A2: prdata = coef_ff.a2;
         default: prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '0;
      end else begin
         coef_ff <= coef_in;
      end
   end

endmodule

>>> sv/mciir_chan.sv
// ----------------------------------------------------------------------------
// mciir_chan: one filter channel
// Tap products, exact sum, rounding and saturation for one channel, plus
// that channel's input and output history.
// ----------------------------------------------------------------------------
module mciir_chan #(
   parameter int ORDER = mciir_pkg::Order
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  mciir_pkg::coef_type    coef,
   input  mciir_pkg::sample_type  x,
   output mciir_pkg::sample_type  y
);

   mciir_pkg::sample_type hist_x_ff [ORDER];
   mciir_pkg::sample_type hist_y_ff [ORDER];

   logic signed [mciir_pkg::SumWidth-1:0] acc;
   logic signed [mciir_pkg::SumWidth-1:0] rounded;
   logic signed [mciir_pkg::SumWidth-1:0] scaled;

   always_comb begin
      logic signed [mciir_pkg::ProdWidth-1:0] prod_b;
      logic signed [mciir_pkg::ProdWidth-1:0] prod_a;
      mciir_pkg::sample_type                  wb;
      mciir_pkg::sample_type                  wa;
      wb     = mciir_pkg::coef_b_at(coef, 0);
      prod_b = wb * x;
      acc    = mciir_pkg::SumWidth'(prod_b);
      for (int k = 1; k <= ORDER; k++) begin
         wb     = mciir_pkg::coef_b_at(coef, k);
         wa     = mciir_pkg::coef_a_at(coef, k);
         prod_b = wb * hist_x_ff[k-1];
         prod_a = wa * hist_y_ff[k-1];
         acc    = acc + mciir_pkg::SumWidth'(prod_b) - mciir_pkg::SumWidth'(prod_a);
      end
      // round half up, then drop the Q4.28 fraction
      rounded = acc + mciir_pkg::HalfLsb;
      scaled  = rounded >>> mciir_pkg::FracDrop;
   end

   always_comb begin
      priority if (scaled > mciir_pkg::SumWidth'(mciir_pkg::SampleMax)) begin
         y = mciir_pkg::SampleMax;
      end else if (scaled < mciir_pkg::SumWidth'(mciir_pkg::SampleMin)) begin
         y = mciir_pkg::SampleMin;
      end else begin
         y = scaled[mciir_pkg::SampleWidth-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < ORDER; k++) begin
            hist_x_ff[k] <= '0;
            hist_y_ff[k] <= '0;
         end
      end else if (advance) begin
         hist_x_ff[0] <= x;
         hist_y_ff[0] <= y;
         for (int k = 1; k < ORDER; k++) begin
            hist_x_ff[k] <= hist_x_ff[k-1];
            hist_y_ff[k] <= hist_y_ff[k-1];
         end
      end
   end

endmodule
